[src/cpg_pkg.sv]
// shared types and constants for the circle point generator
// no dependencies; imported by every module of the block
package cpg_pkg;

	localparam int COORD_BITS = 12;
	localparam int RAD_BITS   = COORD_BITS - 1;
	localparam int PIX_BITS   = COORD_BITS + 2;
	localparam int DEC_BITS   = COORD_BITS + 6;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	localparam int PIX_PER_STEP = 8;
	localparam int IDX_BITS     = $clog2(PIX_PER_STEP);

	// opcodes of an input word
	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	// decision variable constants
	localparam logic [DEC_BITS-1:0] DEC_INIT  = DEC_BITS'(3);
	localparam logic [DEC_BITS-1:0] DEC_DIAG  = DEC_BITS'(10);
	localparam logic [DEC_BITS-1:0] DEC_AXIAL = DEC_BITS'(6);

	// one classified job handed from front to back
	typedef struct packed {
		logic                  idle;   // step with no circle: one empty result
		logic                  done;
		logic [COORD_BITS-1:0] cx;
		logic [COORD_BITS-1:0] cy;
		logic [COORD_BITS-1:0] x;      // two's complement
		logic [COORD_BITS-1:0] y;      // two's complement
	} job_t;

	// queue status seen by the front and back
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

[src/cpg_queue.sv]
// two-entry job queue between front and back of the circle point generator
// depends on cpg_pkg for job_t and queue sizing
module cpg_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  cpg_pkg::job_t         push_job,
	input  logic                  pop,
	output cpg_pkg::job_t         head,
	output cpg_pkg::queue_status_t status
);
	import cpg_pkg::*;

	job_t                entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_CW-1:0] count_q;

	function automatic logic [QUEUE_AW-1:0] ptr_next(input logic [QUEUE_AW-1:0] p);
		logic [QUEUE_AW-1:0] r;
		if (p == QUEUE_AW'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + QUEUE_AW'(1);
		end
		return r;
	endfunction

	assign head         = entry_q[rd_ptr_q];
	assign status.full  = (count_q == QUEUE_CW'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QUEUE_CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QUEUE_CW'(1);
			end
		end
	end

endmodule

[src/cpg_front.sv]
// front of the circle point generator: takes input words, runs the midpoint
// recurrence and pushes one job per word; depends on cpg_pkg
module cpg_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  logic                           op,
	input  logic [cpg_pkg::COORD_BITS-1:0] center_x,
	input  logic [cpg_pkg::COORD_BITS-1:0] center_y,
	input  logic [cpg_pkg::RAD_BITS-1:0]   radius,
	input  cpg_pkg::queue_status_t         qstat,
	output logic                           push,
	output cpg_pkg::job_t                  push_job
);
	import cpg_pkg::*;

	logic [COORD_BITS-1:0] x_q, y_q, cx_q, cy_q;
	logic [DEC_BITS-1:0]   d_q;
	logic                  active_q;

	logic [COORD_BITS-1:0] x_n, y_n, x_st, y_st;
	logic [DEC_BITS-1:0]   d_n, d_st, ext_x, ext_y;
	logic                  go_diag;

	assign item_ready = !qstat.full;
	assign push       = item_valid && item_ready;

	// start values
	assign x_st = '0;
	assign y_st = {1'b0, radius};
	assign d_st = DEC_INIT - {{(DEC_BITS - RAD_BITS - 1){1'b0}}, radius, 1'b0};

	// one octant step
	always_comb begin
		go_diag = ($signed(d_q) > $signed(DEC_BITS'(0)));
		x_n     = x_q + COORD_BITS'(1);
		y_n     = go_diag ? (y_q - COORD_BITS'(1)) : y_q;
		ext_x   = {{(DEC_BITS - COORD_BITS){x_n[COORD_BITS-1]}}, x_n};
		ext_y   = {{(DEC_BITS - COORD_BITS){y_n[COORD_BITS-1]}}, y_n};
		if (go_diag) begin
			d_n = d_q + ((ext_x - ext_y) << 2) + DEC_DIAG;
		end else begin
			d_n = d_q + (ext_x << 2) + DEC_AXIAL;
		end
	end

	always_comb begin
		push_job = '0;
		unique case (op)
			OP_START: begin
				push_job.cx   = center_x;
				push_job.cy   = center_y;
				push_job.x    = x_st;
				push_job.y    = y_st;
				push_job.done = ($signed(y_st) < $signed(x_st));
			end
			OP_STEP: begin
				if (active_q) begin
					push_job.cx   = cx_q;
					push_job.cy   = cy_q;
					push_job.x    = x_n;
					push_job.y    = y_n;
					push_job.done = ($signed(y_n) < $signed(x_n));
				end else begin
					push_job.idle = 1'b1;
					push_job.done = 1'b1;
				end
			end
			default: push_job = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q      <= '0;
			y_q      <= '0;
			d_q      <= '0;
			cx_q     <= '0;
			cy_q     <= '0;
			active_q <= 1'b0;
		end else if (push) begin
			if (op == OP_START) begin
				x_q      <= x_st;
				y_q      <= y_st;
				d_q      <= d_st;
				cx_q     <= center_x;
				cy_q     <= center_y;
				active_q <= 1'b1;
			end else if (active_q) begin
				x_q      <= x_n;
				y_q      <= y_n;
				d_q      <= d_n;
				active_q <= !push_job.done;
			end
		end
	end

endmodule

[src/cpg_back.sv]
// back of the circle point generator: expands each non-idle job into eight mirrored
// pixels, one per unstalled cycle, into a registered result stage; depends on cpg_pkg
module cpg_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cpg_pkg::job_t                       head,
	input  cpg_pkg::queue_status_t              qstat,
	output logic                                pop,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic signed [cpg_pkg::PIX_BITS-1:0] pixel_x,
	output logic signed [cpg_pkg::PIX_BITS-1:0] pixel_y,
	output logic                                pixel_valid,
	output logic                                last_of_step,
	output logic                                circle_done
);
	import cpg_pkg::*;

	job_t                job_q;
	logic                busy_q;
	logic [IDX_BITS-1:0] idx_q;

	logic                out_valid_q;
	logic [PIX_BITS-1:0] px_q, py_q;
	logic                pv_q, last_q, done_q;

	job_t                cur;
	logic                cur_valid, advance, is_last;
	logic [PIX_BITS-1:0] cx14, cy14, a14, b14, px_n, py_n;
	logic [COORD_BITS-1:0] a, b;

	assign cur       = busy_q ? job_q : head;
	assign cur_valid = busy_q || !qstat.empty;
	assign advance   = cur_valid && (!out_valid_q || result_ready);
	assign pop       = advance && !busy_q;
	assign is_last   = cur.idle || (idx_q == IDX_BITS'(PIX_PER_STEP - 1));

	// idx bit 2 swaps x and y, bit 0 negates the column term, bit 1 the row term
	always_comb begin
		a    = idx_q[2] ? cur.y : cur.x;
		b    = idx_q[2] ? cur.x : cur.y;
		cx14 = {{(PIX_BITS - COORD_BITS){1'b0}}, cur.cx};
		cy14 = {{(PIX_BITS - COORD_BITS){1'b0}}, cur.cy};
		a14  = {{(PIX_BITS - COORD_BITS){a[COORD_BITS-1]}}, a};
		b14  = {{(PIX_BITS - COORD_BITS){b[COORD_BITS-1]}}, b};
		px_n = idx_q[0] ? (cx14 - a14) : (cx14 + a14);
		py_n = idx_q[1] ? (cy14 - b14) : (cy14 + b14);
		if (cur.idle) begin
			px_n = '0;
			py_n = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head;
		end
		if (advance) begin
			px_q   <= px_n;
			py_q   <= py_n;
			pv_q   <= !cur.idle;
			last_q <= is_last;
			done_q <= cur.done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				if (is_last) begin
					busy_q <= 1'b0;
					idx_q  <= '0;
				end else begin
					busy_q <= 1'b1;
					idx_q  <= idx_q + IDX_BITS'(1);
				end
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign pixel_x      = $signed(px_q);
	assign pixel_y      = $signed(py_q);
	assign pixel_valid  = pv_q;
	assign last_of_step = last_q;
	assign circle_done  = done_q;

endmodule

[src/circle_point_generator_unit.sv]
// top level of the midpoint circle point generator
// instantiates cpg_front, cpg_queue and cpg_back; depends on cpg_pkg
//
// input channel (item_valid/item_ready): op = start latches center and radius
// and yields the eight pixels of (0, r); op = step advances x by one and
// yields the eight mirrored pixels of the new point. a step with no circle in
// progress yields one word with pixel_valid low, marked last and done.
// result channel (result_valid/result_ready): one pixel word per cycle unless
// the receiver stalls, the eighth of each step marked last_of_step, circle_done
// set on all words of the step where y drops below x.
// the first pixel of an input word reaches the output through the two-entry job
// queue and then the result register that the back loads.
// the pace of the unit is set by the single result port of the back end, which
// emits the eight words of a start or step, or the one word of an idle step, in
// turn; the front runs one word per cycle until the queue fills.
// a stalled receiver holds the result register; the queue then fills and
// item_ready drops. reset clears the recurrence state, queue and result valid.
module circle_point_generator_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  logic                                op,
	input  logic [cpg_pkg::COORD_BITS-1:0]      center_x,
	input  logic [cpg_pkg::COORD_BITS-1:0]      center_y,
	input  logic [cpg_pkg::RAD_BITS-1:0]        radius,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic signed [cpg_pkg::PIX_BITS-1:0] pixel_x,
	output logic signed [cpg_pkg::PIX_BITS-1:0] pixel_y,
	output logic                                pixel_valid,
	output logic                                last_of_step,
	output logic                                circle_done
);
	import cpg_pkg::*;

	job_t          push_job, head;
	logic          push, pop;
	queue_status_t qstat;

	cpg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.op         (op),
		.center_x   (center_x),
		.center_y   (center_y),
		.radius     (radius),
		.qstat      (qstat),
		.push       (push),
		.push_job   (push_job)
	);

	cpg_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.status   (qstat)
	);

	cpg_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.qstat        (qstat),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.pixel_valid  (pixel_valid),
		.last_of_step (last_of_step),
		.circle_done  (circle_done)
	);

endmodule
